// ----- rtl/core/turbo_colormap_polynomial_rgb_macros.svh -----
// Assertion macros used by the colormap top module.
// Each macro expects clk and rst to be visible where it is used.
`ifndef TURBO_COLORMAP_POLYNOMIAL_RGB_MACROS_SVH
`define TURBO_COLORMAP_POLYNOMIAL_RGB_MACROS_SVH

// Check that prop holds in the same cycle as cond.
`define TCP_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("turbo colormap: same-cycle check failed");

// Check that prop holds in the cycle after cond.
`define TCP_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("turbo colormap: next-cycle check failed");

`endif

// ----- rtl/core/tcp_pkg.sv -----
`default_nettype none

package tcp_pkg;

  localparam int INPUT_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS  = 24;
  localparam int SAMPLE_W        = 18;
  localparam int X_W             = INPUT_FRAC_BITS + 1;
  // Sign, nine integer bits of headroom and the coefficient fraction.
  localparam int ACC_W           = COEF_FRAC_BITS + 10;
  localparam int PROD_W          = ACC_W + X_W;
  localparam int PIX_W           = 8;
  localparam int SCALED_W        = COEF_FRAC_BITS + PIX_W;
  localparam int NUM_CH          = 3;
  localparam int NUM_STEPS       = 5;
  localparam int NUM_TERMS       = NUM_STEPS + 1;

  localparam longint unsigned DEC_SCALE = 64'd100000000;

  typedef logic [X_W-1:0]            x_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef acc_t [NUM_CH-1:0]         acc_vec_t;

  typedef struct packed {
    acc_vec_t acc;
    x_t       x;
  } stage_t;

  // Coefficients in units of 1e-8, constant term first: red, green, blue.
  localparam longint POLY_DEC [NUM_CH][NUM_TERMS] = '{
    '{64'sd13572138, 64'sd461539260, -64'sd4266032258, 64'sd13213108234,
      -64'sd15294239396, 64'sd5928637943},
    '{64'sd9140261, 64'sd219418839, 64'sd484296658, -64'sd1418503333,
      64'sd427729857, 64'sd282956604},
    '{64'sd10667330, 64'sd1264194608, -64'sd6058204836, 64'sd11036276771,
      -64'sd8990310912, 64'sd2734824973}
  };

  // Round a decimal coefficient to fixed point, ties away from zero.
  function automatic acc_t coef_fixed(longint n);
    logic            neg;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned r;
    longint unsigned v;
    neg = (n < 0);
    mag = neg ? 64'(-n) : 64'(n);
    q   = mag / DEC_SCALE;
    r   = mag % DEC_SCALE;
    v   = (q << COEF_FRAC_BITS) + (((r << COEF_FRAC_BITS) + DEC_SCALE / 2) / DEC_SCALE);
    return neg ? -ACC_W'(v) : ACC_W'(v);
  endfunction

  function automatic acc_t coef_of(int ch, int k);
    return coef_fixed(POLY_DEC[ch][k]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tcp_if.sv -----
`default_nettype none

interface tcp_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [tcp_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface tcp_rgb_if;
  logic                          valid;
  logic                          ready;
  logic [tcp_pkg::PIX_W-1:0]     red;
  logic [tcp_pkg::PIX_W-1:0]     green;
  logic [tcp_pkg::PIX_W-1:0]     blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/tcp_horner_cell.sv -----
`default_nettype none

module tcp_horner_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  tcp_pkg::stage_t   up_data,
  input  tcp_pkg::acc_vec_t coef,
  output logic              down_valid,
  input  logic              down_ready,
  output tcp_pkg::stage_t   down_data
);
  import tcp_pkg::*;

  logic [ACC_W-1:0]  mag  [NUM_CH];
  logic [PROD_W-1:0] prod [NUM_CH];
  logic [ACC_W-1:0]  rnd  [NUM_CH];
  stage_t            data_next;

  // One Horner step per channel: acc * x, round on magnitude, add coefficient.
  always_comb begin
    data_next.x = up_data.x;
    for (int c = 0; c < NUM_CH; c++) begin
      mag[c]  = up_data.acc[c][ACC_W-1] ? ACC_W'(-$signed(up_data.acc[c])) : up_data.acc[c];
      prod[c] = PROD_W'(mag[c]) * PROD_W'(up_data.x);
      rnd[c]  = ACC_W'(prod[c][PROD_W-1:INPUT_FRAC_BITS])
              + ACC_W'(prod[c][INPUT_FRAC_BITS-1]);
      data_next.acc[c] = (up_data.acc[c][ACC_W-1] ? -$signed(rnd[c]) : $signed(rnd[c]))
                       + $signed(coef[c]);
    end
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcp_out_stage.sv -----
`default_nettype none

module tcp_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  tcp_pkg::stage_t up_data,
  tcp_rgb_if.source       pixel
);
  import tcp_pkg::*;

  localparam acc_t ONE = acc_t'(1) <<< COEF_FRAC_BITS;

  logic [COEF_FRAC_BITS-1:0] frac   [NUM_CH];
  logic [SCALED_W-1:0]       scaled [NUM_CH];
  logic [PIX_W-1:0]          pix    [NUM_CH];

  // Clamp to [0,1], scale by 255 and round to nearest.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      frac[c]   = up_data.acc[c][COEF_FRAC_BITS-1:0];
      scaled[c] = (SCALED_W'(frac[c]) << PIX_W) - SCALED_W'(frac[c])
                + (SCALED_W'(1) << (COEF_FRAC_BITS - 1));
      if ($signed(up_data.acc[c]) <= 0) begin
        pix[c] = '0;
      end else if ($signed(up_data.acc[c]) >= ONE) begin
        pix[c] = '1;
      end else begin
        pix[c] = scaled[c][SCALED_W-1:COEF_FRAC_BITS];
      end
    end
  end

  assign up_ready = !pixel.valid || pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (up_ready) begin
      pixel.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pixel.red   <= pix[0];
      pixel.green <= pix[1];
      pixel.blue  <= pix[2];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/turbo_colormap_polynomial_rgb.sv -----
// Turbo colormap, quintic polynomial form, fixed point.
// Channel sample (sink): one signed Q1.16 sample_value per item; values below
//   zero map to 0.0, values above one map to 1.0.
// Channel pixel (source): one item of red, green and blue, 8 bits each, for
//   every sample item, in order. Alpha is always 255 and not carried.
// Both channels move an item on a rising edge with valid and ready high.
// Pipeline: six registers lie between the edge that accepts the sample and
//   pixel valid: five Horner cells, each one multiply-round-add step for
//   all three channels, then the clamp/scale/round output register.
// Throughput: one item per cycle while pixel.ready is high, set by the chain
//   of cells, each taking a new item in the cycle its previous one moves on.
// Stalls: each cell holds its item while the next is full and stalled; empty
//   cells still fill, so bubbles collapse and sample.ready only drops once the
//   whole chain is full behind a stalled pixel channel.
// Reset (rst, synchronous, active high): clears every valid flag in the chain;
//   items in flight are dropped and the block is ready in the next cycle.
`default_nettype none
`include "turbo_colormap_polynomial_rgb_macros.svh"

module turbo_colormap_polynomial_rgb (
  input  logic      clk,
  input  logic      rst,
  tcp_sample_if.sink sample,
  tcp_rgb_if.source  pixel
);
  import tcp_pkg::*;

  localparam x_t X_ONE = x_t'(1) << INPUT_FRAC_BITS;

  // Link g feeds cell g; link NUM_STEPS feeds the output stage.
  stage_t               link       [NUM_STEPS+1];
  logic [NUM_STEPS:0]   link_valid;
  logic [NUM_STEPS:0]   link_ready;
  acc_vec_t             cell_coef  [NUM_STEPS];
  x_t                   x_clamped;

  // Clamp the sample to [0,1]: drop negatives to zero, saturate above one.
  always_comb begin
    if (sample.sample_value[SAMPLE_W-1]) begin
      x_clamped = '0;
    end else if (sample.sample_value[SAMPLE_W-2:0] > (SAMPLE_W-1)'(X_ONE)) begin
      x_clamped = X_ONE;
    end else begin
      x_clamped = X_W'(sample.sample_value[SAMPLE_W-2:0]);
    end
  end

  // Head of the chain: leading coefficient enters as the accumulator.
  always_comb begin
    link[0].x = x_clamped;
    for (int c = 0; c < NUM_CH; c++) begin
      link[0].acc[c] = coef_of(c, NUM_STEPS);
    end
  end

  assign link_valid[0] = sample.valid;
  assign sample.ready  = link_ready[0];

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
    // Cell g adds the coefficient of degree NUM_STEPS-1-g.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_coef
      assign cell_coef[g][c] = coef_of(c, NUM_STEPS - 1 - g);
    end

    tcp_horner_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (link_valid[g]),
      .up_ready   (link_ready[g]),
      .up_data    (link[g]),
      .coef       (cell_coef[g]),
      .down_valid (link_valid[g+1]),
      .down_ready (link_ready[g+1]),
      .down_data  (link[g+1])
    );
  end

  tcp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (link_valid[NUM_STEPS]),
    .up_ready (link_ready[NUM_STEPS]),
    .up_data  (link[NUM_STEPS]),
    .pixel    (pixel)
  );

  // An accepted sample lands in the first cell.
  `TCP_ASSERT_NXT(a_accept_fills_first, sample.valid && sample.ready, link_valid[1])
  // A full chain behind a stalled pixel channel takes no sample.
  `TCP_ASSERT_IMP(a_full_blocks_input,
                  (&link_valid[NUM_STEPS:1]) && pixel.valid && !pixel.ready,
                  !sample.ready)
  // The last cell holds its item while the output stage refuses it.
  `TCP_ASSERT_NXT(a_last_cell_holds,
                  link_valid[NUM_STEPS] && !link_ready[NUM_STEPS],
                  link_valid[NUM_STEPS])

endmodule

`default_nettype wire
